// ----- rtl/lic_pkg.sv -----
// Shared constants, types and helper functions of the LRU id cache.
`timescale 1ns / 1ps

package lic_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int RANK_W  = IDX_W;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;
	localparam int KEY_W   = 31;
	localparam int STAMP_W = 64;
	localparam int OP_W    = 3;
	localparam int CNT_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_TOUCH  = 3'd2;
	localparam logic [OP_W-1:0] OP_PROBE  = 3'd3;
	localparam logic [OP_W-1:0] OP_SWEEP  = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

	localparam logic [2:0] RK_HOLD    = 3'd0;
	localparam logic [2:0] RK_PROMOTE = 3'd1;
	localparam logic [2:0] RK_DROP    = 3'd2;
	localparam logic [2:0] RK_INSERT  = 3'd3;
	localparam logic [2:0] RK_SWEEP   = 3'd4;
	localparam logic [2:0] RK_CLEAR   = 3'd5;

	typedef logic [ENTRIES-1:0][RANK_W-1:0] rank_arr_t;

	// Order update request from the cache control to the rank logic.
	typedef struct packed {
		logic [2:0]         mode;
		logic [IDX_W-1:0]   idx;
		logic [RANK_W-1:0]  ref_rank;
		logic [ENTRIES-1:0] mask;
	} rank_ctl_t;

	function automatic logic [ENTRIES-1:0] lowest_onehot(input logic [ENTRIES-1:0] v);
		return v & (~v + ENTRIES'(1));
	endfunction

	function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [ENTRIES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (v[i]) begin
				r = r | IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/lic_rank_update.sv -----
// Next least-recently-used rank of every entry for one cache operation.
`timescale 1ns / 1ps

module lic_rank_update (
	input  lic_pkg::rank_arr_t             rank,
	input  logic [lic_pkg::ENTRIES-1:0]    valid,
	input  lic_pkg::rank_ctl_t             ctl,
	output lic_pkg::rank_arr_t             rank_next
);

	always_comb begin
		logic [lic_pkg::ENTRIES-1:0] below;
		logic                        is_sel;
		rank_next = rank;
		for (int i = 0; i < lic_pkg::ENTRIES; i++) begin
			is_sel = (ctl.idx == lic_pkg::IDX_W'(i));
			// Survivors of a sweep ranked ahead of this one give its new rank.
			below = '0;
			for (int j = 0; j < lic_pkg::ENTRIES; j++) begin
				below[j] = ctl.mask[j] && (rank[j] < rank[i]);
			end
			case (ctl.mode)
				lic_pkg::RK_PROMOTE: begin
					if (is_sel) begin
						rank_next[i] = '0;
					end else if (valid[i] && rank[i] < ctl.ref_rank) begin
						rank_next[i] = rank[i] + lic_pkg::RANK_W'(1);
					end
				end
				lic_pkg::RK_DROP: begin
					if (is_sel) begin
						rank_next[i] = '0;
					end else if (valid[i] && rank[i] > ctl.ref_rank) begin
						rank_next[i] = rank[i] - lic_pkg::RANK_W'(1);
					end
				end
				lic_pkg::RK_INSERT: begin
					if (is_sel) begin
						rank_next[i] = '0;
					end else if (ctl.mask[i]) begin
						rank_next[i] = rank[i] + lic_pkg::RANK_W'(1);
					end else begin
						rank_next[i] = '0;
					end
				end
				lic_pkg::RK_SWEEP: begin
					rank_next[i] = ctl.mask[i] ? lic_pkg::RANK_W'($countones(below)) : '0;
				end
				lic_pkg::RK_CLEAR: begin
					rank_next[i] = '0;
				end
				default: begin
					rank_next[i] = rank[i];
				end
			endcase
		end
	end

endmodule

// ----- rtl/lru_id_cache_unit.sv -----
// Top level of the fully associative LRU id cache.
`timescale 1ns / 1ps

// One operation is accepted on every cycle (busy is always low). Its result is
// strobed on done after passing through the input register and then through
// the key match and entry update logic into the result register. All sixteen
// entries are compared and re-ranked in that single pass, so the next operation
// always sees the updated contents. The result is shown for one cycle only and
// must be taken then. The capacity register may be written at any time the cache
// is idle; cfg_ready is always high. Capacity zero acts as one, and values above
// the entry count saturate.
module lru_id_cache_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [lic_pkg::OP_W-1:0]          operation,
	input  logic [lic_pkg::KEY_W-1:0]         cluster_key,
	input  logic [lic_pkg::KEY_W-1:0]         proc_key,
	input  logic [lic_pkg::KEY_W-1:0]         job_value,
	input  logic [lic_pkg::KEY_W-1:0]         list_value,
	input  logic signed [lic_pkg::STAMP_W-1:0] stamp,
	output logic                              done,
	output logic                              hit,
	output logic [lic_pkg::KEY_W-1:0]         job_out,
	output logic [lic_pkg::KEY_W-1:0]         list_out,
	output logic                              evicted,
	output logic [lic_pkg::CNT_W-1:0]         removed_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lic_pkg::CAP_W-1:0]         cfg_data
);

	// Input register
	logic                                vld_s1;
	logic [lic_pkg::OP_W-1:0]            op_s1;
	logic [lic_pkg::KEY_W-1:0]           ck_s1, pk_s1, job_s1, list_s1;
	logic signed [lic_pkg::STAMP_W-1:0]  stamp_s1;

	// Entry store
	logic [lic_pkg::ENTRIES-1:0]         valid_q;
	lic_pkg::rank_arr_t                  rank_q;
	logic [lic_pkg::OCC_W-1:0]           occ_q;
	logic [lic_pkg::CAP_W-1:0]           cap_q;
	logic [lic_pkg::KEY_W-1:0]           cl_q   [lic_pkg::ENTRIES];
	logic [lic_pkg::KEY_W-1:0]           pr_q   [lic_pkg::ENTRIES];
	logic [lic_pkg::KEY_W-1:0]           jb_q   [lic_pkg::ENTRIES];
	logic [lic_pkg::KEY_W-1:0]           ls_q   [lic_pkg::ENTRIES];
	logic signed [lic_pkg::STAMP_W-1:0]  tm_q   [lic_pkg::ENTRIES];

	// Result register
	logic                                done_q, hit_q, evicted_q;
	logic [lic_pkg::KEY_W-1:0]           job_q, list_q;
	logic [lic_pkg::CNT_W-1:0]           rc_q;

	// Single-pass logic
	logic [lic_pkg::ENTRIES-1:0]         match, lru_hot, evict_hot, free_hot, slot_hot, kill;
	logic                                hit_any, need_evict, older, do_write, do_time;
	logic [lic_pkg::IDX_W-1:0]           hit_idx, slot_idx, wr_idx;
	logic [lic_pkg::CMP_W-1:0]           cap_ext, cap_eff, occ_ext;
	logic [lic_pkg::OCC_W-1:0]           kill_cnt;
	lic_pkg::rank_ctl_t                  rctl;
	lic_pkg::rank_arr_t                  rank_next;
	logic [lic_pkg::ENTRIES-1:0]         valid_next;
	logic [lic_pkg::OCC_W-1:0]           occ_next;
	logic                                hit_d, evicted_d;
	logic [lic_pkg::KEY_W-1:0]           job_d, list_d;
	logic [lic_pkg::CNT_W-1:0]           rc_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= operation;
			ck_s1    <= cluster_key;
			pk_s1    <= proc_key;
			job_s1   <= job_value;
			list_s1  <= list_value;
			stamp_s1 <= stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lic_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < lic_pkg::ENTRIES; i++) begin
			match[i]   = valid_q[i] && cl_q[i] == ck_s1 && pr_q[i] == pk_s1;
			// Ranks of valid entries run from zero to occupancy less one.
			lru_hot[i] = valid_q[i] && rank_q[i] == lic_pkg::RANK_W'(occ_q - lic_pkg::OCC_W'(1));
			kill[i]    = valid_q[i] && (tm_q[i] < stamp_s1);
		end
	end

	assign hit_any  = |match;
	assign hit_idx  = lic_pkg::onehot_to_idx(lic_pkg::lowest_onehot(match));
	assign kill_cnt = lic_pkg::OCC_W'($countones(kill));

	assign cap_ext = lic_pkg::CMP_W'(cap_q);
	assign occ_ext = lic_pkg::CMP_W'(occ_q);
	always_comb begin
		if (cap_ext == '0) begin
			cap_eff = lic_pkg::CMP_W'(1);
		end else if (cap_ext > lic_pkg::CMP_W'(lic_pkg::ENTRIES)) begin
			cap_eff = lic_pkg::CMP_W'(lic_pkg::ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign need_evict = (op_s1 == lic_pkg::OP_INSERT) && !hit_any && (occ_ext >= cap_eff);
	assign evict_hot  = need_evict ? lru_hot : '0;
	// The evicted entry's place is free for the new key as well.
	assign free_hot   = ~valid_q | evict_hot;
	assign slot_hot   = lic_pkg::lowest_onehot(free_hot);
	assign slot_idx   = lic_pkg::onehot_to_idx(slot_hot);
	assign wr_idx     = hit_any ? hit_idx : slot_idx;
	assign older      = tm_q[hit_idx] < stamp_s1;

	assign do_write = vld_s1 && (op_s1 == lic_pkg::OP_INSERT);
	assign do_time  = do_write || (vld_s1 && (op_s1 == lic_pkg::OP_TOUCH) && hit_any && older);

	always_comb begin
		rctl          = '0;
		rctl.mode     = lic_pkg::RK_HOLD;
		rctl.idx      = hit_idx;
		rctl.ref_rank = rank_q[hit_idx];
		valid_next    = valid_q;
		occ_next      = occ_q;
		hit_d         = 1'b0;
		job_d         = '0;
		list_d        = '0;
		evicted_d     = 1'b0;
		rc_d          = '0;
		case (op_s1)
			lic_pkg::OP_LOOKUP: begin
				if (hit_any) begin
					hit_d     = 1'b1;
					job_d     = jb_q[hit_idx];
					list_d    = ls_q[hit_idx];
					rctl.mode = lic_pkg::RK_PROMOTE;
				end
			end
			lic_pkg::OP_INSERT: begin
				if (hit_any) begin
					hit_d     = 1'b1;
					rctl.mode = lic_pkg::RK_PROMOTE;
				end else begin
					evicted_d  = need_evict;
					rctl.mode  = lic_pkg::RK_INSERT;
					rctl.idx   = slot_idx;
					rctl.mask  = valid_q & ~evict_hot;
					valid_next = (valid_q & ~evict_hot) | slot_hot;
					if (!need_evict) begin
						occ_next = occ_q + lic_pkg::OCC_W'(1);
					end
				end
			end
			lic_pkg::OP_TOUCH: begin
				if (hit_any) begin
					hit_d     = 1'b1;
					rctl.mode = lic_pkg::RK_PROMOTE;
				end
			end
			lic_pkg::OP_PROBE: begin
				hit_d = hit_any;
			end
			lic_pkg::OP_SWEEP: begin
				rctl.mode  = lic_pkg::RK_SWEEP;
				rctl.mask  = valid_q & ~kill;
				valid_next = valid_q & ~kill;
				occ_next   = occ_q - kill_cnt;
				rc_d       = lic_pkg::CNT_W'(kill_cnt);
			end
			lic_pkg::OP_REMOVE: begin
				if (hit_any) begin
					hit_d            = 1'b1;
					rctl.mode        = lic_pkg::RK_DROP;
					valid_next[hit_idx] = 1'b0;
					occ_next         = occ_q - lic_pkg::OCC_W'(1);
					rc_d             = lic_pkg::CNT_W'(1);
				end
			end
			lic_pkg::OP_CLEAR: begin
				rctl.mode  = lic_pkg::RK_CLEAR;
				valid_next = '0;
				occ_next   = '0;
				rc_d       = lic_pkg::CNT_W'(occ_q);
			end
			default: begin
				rctl.mode = lic_pkg::RK_HOLD;
			end
		endcase
	end

	lic_rank_update u_rank (
		.rank      (rank_q),
		.valid     (valid_q),
		.ctl       (rctl),
		.rank_next (rank_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
			occ_q   <= '0;
		end else if (vld_s1) begin
			valid_q <= valid_next;
			rank_q  <= rank_next;
			occ_q   <= occ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			if (!hit_any) begin
				cl_q[wr_idx] <= ck_s1;
				pr_q[wr_idx] <= pk_s1;
			end
			jb_q[wr_idx] <= job_s1;
			ls_q[wr_idx] <= list_s1;
		end
		if (do_time) begin
			tm_q[wr_idx] <= stamp_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_q     <= hit_d;
			job_q     <= job_d;
			list_q    <= list_d;
			evicted_q <= evicted_d;
			rc_q      <= rc_d;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign job_out       = job_q;
	assign list_out      = list_q;
	assign evicted       = evicted_q;
	assign removed_count = rc_q;

endmodule

// ----- rtl/lic_checker.sv -----
// Port-level checks of the LRU id cache and their binding to the top level.
`timescale 1ns / 1ps

module lic_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        hit,
	input logic [lic_pkg::KEY_W-1:0]   job_out,
	input logic                        evicted,
	input logic [lic_pkg::CNT_W-1:0]   removed_count
);

	// Every accepted beat yields its result on done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted beat");

	// Eviction only happens when a new key is inserted, so it comes with no hit and no removals.
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> !hit && removed_count == '0)
		else $error("eviction reported on a hit or with removals");

	a_job_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && job_out != '0 |-> hit)
		else $error("job id returned without a hit");

endmodule

bind lru_id_cache_unit lic_checker u_lic_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.job_out       (job_out),
	.evicted       (evicted),
	.removed_count (removed_count)
);

// ----- tb/sv/lic_result_checker.sv -----
// Result checker of the LRU id cache: a cache model that predicts and compares every result.
`timescale 1ns / 1ps

module lic_result_checker
	import lic_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [OP_W-1:0]           operation,
	input  logic [KEY_W-1:0]          cluster_key,
	input  logic [KEY_W-1:0]          proc_key,
	input  logic [KEY_W-1:0]          job_value,
	input  logic [KEY_W-1:0]          list_value,
	input  logic signed [STAMP_W-1:0] stamp,
	input  logic                      done,
	input  logic                      hit,
	input  logic [KEY_W-1:0]          job_out,
	input  logic [KEY_W-1:0]          list_out,
	input  logic                      evicted,
	input  logic [CNT_W-1:0]          removed_count,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CAP_W-1:0]          cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        results_seen,
	output int                        hits_seen,
	output int                        evictions_seen
);

	typedef struct packed {
		logic             hit;
		logic [KEY_W-1:0] job;
		logic [KEY_W-1:0] lst;
		logic             evicted;
		logic [CNT_W-1:0] removed;
	} cache_result_t;

	localparam int REPORT_LIMIT = 10;

	// Mirror of the cache contents; rank 0 is the most recently used entry.
	logic                      ent_valid   [ENTRIES];
	logic [KEY_W-1:0]          ent_cluster [ENTRIES];
	logic [KEY_W-1:0]          ent_proc    [ENTRIES];
	logic [KEY_W-1:0]          ent_job     [ENTRIES];
	logic [KEY_W-1:0]          ent_list    [ENTRIES];
	logic signed [STAMP_W-1:0] ent_stamp   [ENTRIES];
	logic [RANK_W-1:0]         ent_rank    [ENTRIES];
	int                        occ;
	logic [CAP_W-1:0]          cap_reg;

	cache_result_t expected_results[$];

	function automatic int find_entry(input logic [KEY_W-1:0] c, input logic [KEY_W-1:0] p);
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i] && ent_cluster[i] == c && ent_proc[i] == p) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void promote_entry(input int e);
		logic [RANK_W-1:0] r;
		r = ent_rank[e];
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i] && ent_rank[i] < r) begin
				ent_rank[i] = ent_rank[i] + 1'b1;
			end
		end
		ent_rank[e] = '0;
	endfunction

	function automatic void drop_entry(input int e);
		logic [RANK_W-1:0] r;
		r = ent_rank[e];
		ent_valid[e] = 1'b0;
		ent_rank[e] = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i] && ent_rank[i] > r) begin
				ent_rank[i] = ent_rank[i] - 1'b1;
			end
		end
		if (occ > 0) begin
			occ = occ - 1;
		end
	endfunction

	// Entries older than the threshold go; the survivors are re-ranked densely
	// in their previous order.
	function automatic logic [CNT_W-1:0] sweep_older(input logic signed [STAMP_W-1:0] thr);
		logic [RANK_W-1:0] fresh [ENTRIES];
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i] && ent_stamp[i] < thr) begin
				ent_valid[i] = 1'b0;
				n++;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			fresh[i] = '0;
			if (ent_valid[i]) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (ent_valid[j] && ent_rank[j] < ent_rank[i]) begin
						fresh[i] = fresh[i] + 1'b1;
					end
				end
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			ent_rank[i] = fresh[i];
		end
		occ = (occ >= n) ? occ - n : 0;
		return CNT_W'(n);
	endfunction

	// A new key evicts exactly one entry when the cache is at capacity, even if
	// the capacity has since been lowered below the occupancy.
	function automatic logic insert_entry(input logic [KEY_W-1:0] c, input logic [KEY_W-1:0] p,
			input logic [KEY_W-1:0] j, input logic [KEY_W-1:0] l,
			input logic signed [STAMP_W-1:0] s);
		int cap_eff;
		int lru;
		int slot;
		logic ev;
		cap_eff = (cap_reg == 0) ? 1 : ((int'(cap_reg) > ENTRIES) ? ENTRIES : int'(cap_reg));
		ev = 1'b0;
		slot = -1;
		if (occ >= cap_eff) begin
			lru = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (ent_valid[i] && (lru < 0 || ent_rank[i] > ent_rank[lru])) begin
					lru = i;
				end
			end
			if (lru >= 0) begin
				drop_entry(lru);
				ev = 1'b1;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i]) begin
				ent_rank[i] = ent_rank[i] + 1'b1;
			end else if (slot < 0) begin
				slot = i;
			end
		end
		if (slot >= 0) begin
			ent_valid[slot] = 1'b1;
			ent_cluster[slot] = c;
			ent_proc[slot] = p;
			ent_job[slot] = j;
			ent_list[slot] = l;
			ent_stamp[slot] = s;
			ent_rank[slot] = '0;
			occ = occ + 1;
		end
		return ev;
	endfunction

	function automatic cache_result_t predict_cache_op(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] c, input logic [KEY_W-1:0] p,
			input logic [KEY_W-1:0] j, input logic [KEY_W-1:0] l,
			input logic signed [STAMP_W-1:0] s);
		cache_result_t res;
		int e;
		res = '0;
		e = find_entry(c, p);
		case (op)
			OP_LOOKUP: begin
				if (e >= 0) begin
					res.hit = 1'b1;
					res.job = ent_job[e];
					res.lst = ent_list[e];
					promote_entry(e);
				end
			end
			OP_INSERT: begin
				if (e >= 0) begin
					res.hit = 1'b1;
					ent_job[e] = j;
					ent_list[e] = l;
					ent_stamp[e] = s;
					promote_entry(e);
				end else begin
					res.evicted = insert_entry(c, p, j, l, s);
				end
			end
			OP_TOUCH: begin
				if (e >= 0) begin
					res.hit = 1'b1;
					if (ent_stamp[e] < s) begin
						ent_stamp[e] = s;
					end
					promote_entry(e);
				end
			end
			OP_PROBE: begin
				res.hit = (e >= 0);
			end
			OP_SWEEP: begin
				res.removed = sweep_older(s);
			end
			OP_REMOVE: begin
				if (e >= 0) begin
					res.hit = 1'b1;
					drop_entry(e);
					res.removed = CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (ent_valid[i]) begin
						res.removed = res.removed + 1'b1;
					end
					ent_valid[i] = 1'b0;
					ent_rank[i] = '0;
				end
				occ = 0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cache_result_t exp_res;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				ent_valid[i] = 1'b0;
				ent_rank[i] = '0;
			end
			occ = 0;
			cap_reg = CAP_RESET;
			expected_results.delete();
			pending = 0;
			fail_count = 0;
			results_seen = 0;
			hits_seen = 0;
			evictions_seen = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("[%0t] result beat with no operation outstanding", $time);
					end
				end else begin
					exp_res = expected_results.pop_front();
					hits_seen += exp_res.hit;
					evictions_seen += exp_res.evicted;
					if (hit !== exp_res.hit || job_out !== exp_res.job || list_out !== exp_res.lst
							|| evicted !== exp_res.evicted
							|| removed_count !== exp_res.removed) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display({"[%0t] mismatch: expected hit=%0b job=%0d list=%0d",
								" evicted=%0b removed=%0d"},
								$time, exp_res.hit, exp_res.job, exp_res.lst, exp_res.evicted,
								exp_res.removed);
							$display({"            got      hit=%0b job=%0d list=%0d",
								" evicted=%0b removed=%0d"},
								hit, job_out, list_out, evicted, removed_count);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				cap_reg = cfg_data;
			end
			if (start && !busy) begin
				exp_res = predict_cache_op(operation, cluster_key, proc_key,
					job_value, list_value, stamp);
				expected_results.insert(expected_results.size(), exp_res);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the LRU id cache testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
	import lic_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
	localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int STALL_LIMIT = 1000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [OP_W-1:0]           operation;
	logic [KEY_W-1:0]          cluster_key;
	logic [KEY_W-1:0]          proc_key;
	logic [KEY_W-1:0]          job_value;
	logic [KEY_W-1:0]          list_value;
	logic signed [STAMP_W-1:0] stamp;
	logic                      done;
	logic                      hit;
	logic [KEY_W-1:0]          job_out;
	logic [KEY_W-1:0]          list_out;
	logic                      evicted;
	logic [CNT_W-1:0]          removed_count;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CAP_W-1:0]          cfg_data;

	int fail_count;
	int pending;
	int results_seen;
	int hits_seen;
	int evictions_seen;
	int ops_sent;
	int stall_cycles;

	// A small key space per phase so that lookups hit and inserts evict.
	logic [KEY_W-1:0]          cluster_pool [5];
	logic [KEY_W-1:0]          proc_pool    [5];
	logic signed [STAMP_W-1:0] stamp_base;

	lru_id_cache_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.cluster_key   (cluster_key),
		.proc_key      (proc_key),
		.job_value     (job_value),
		.list_value    (list_value),
		.stamp         (stamp),
		.done          (done),
		.hit           (hit),
		.job_out       (job_out),
		.list_out      (list_out),
		.evicted       (evicted),
		.removed_count (removed_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	lic_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.cluster_key    (cluster_key),
		.proc_key       (proc_key),
		.job_value      (job_value),
		.list_value     (list_value),
		.stamp          (stamp),
		.done           (done),
		.hit            (hit),
		.job_out        (job_out),
		.list_out       (list_out),
		.evicted        (evicted),
		.removed_count  (removed_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.hits_seen      (hits_seen),
		.evictions_seen (evictions_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Issues one operation, optionally after a short gap, and returns at the
	// edge on which the beat is taken.
	task automatic issue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] c,
			input logic [KEY_W-1:0] p, input logic [KEY_W-1:0] j, input logic [KEY_W-1:0] l,
			input logic signed [STAMP_W-1:0] s, input int gap_pct);
		int gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		cluster_key <= c;
		proc_key <= p;
		job_value <= j;
		list_value <= l;
		stamp <= s;
		do @(posedge clk); while (busy);
		ops_sent++;
	endtask

	task automatic wait_drained();
		int quiet;
		quiet = 0;
		start <= 1'b0;
		while (quiet < 8) begin
			@(posedge clk);
			quiet = (pending == 0) ? quiet + 1 : 0;
		end
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [OP_W-1:0] pick_op(input bit fill);
		int r;
		r = $urandom_range(0, 99);
		if (r < 26) return OP_LOOKUP;
		if (r < 56) return OP_INSERT;
		if (r < 68) return OP_TOUCH;
		if (r < 77) return OP_PROBE;
		if (r < 97 && fill) return OP_INSERT;
		if (r < 86) return OP_REMOVE;
		if (r < 94) return OP_SWEEP;
		if (r < 97) return OP_CLEAR;
		return OP_SPARE;
	endfunction

	// Mostly stamps in a narrow window above the phase base, so that sweeps
	// drop only part of the cache; the rest span the whole signed range.
	function automatic logic signed [STAMP_W-1:0] pick_stamp(input int spread);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return {$urandom, $urandom};
		if (r < 14) return STAMP_MIN;
		if (r < 16) return STAMP_MAX;
		return stamp_base + $signed(STAMP_W'($urandom_range(0, spread)));
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] pool [5]);
		if ($urandom_range(0, 99) < 5) begin
			return KEY_W'($urandom);
		end
		return pool[$urandom_range(0, 4)];
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int cap_plan [PHASES];
		int gap_plan [PHASES];
		bit fill_plan [PHASES];
		logic [OP_W-1:0] op;
		logic [CAP_W-1:0] cap_val;
		cap_plan = '{16, 1, 0, 31, 3, 17, -1, 16};
		gap_plan = '{0, 60, 20, 0, 60, 20, 0, 60};
		fill_plan = '{1, 0, 0, 1, 0, 0, 0, 0};
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_LOOKUP;
		cluster_key = '0;
		proc_key = '0;
		job_value = '0;
		list_value = '0;
		stamp = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		ops_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset capacity: empty cache, extreme keys and
		// stamps, update of a present key, touch both ways, misses, spare code.
		issue_op(OP_LOOKUP, '0, '0, '0, '0, '0, 0);
		issue_op(OP_INSERT, '0, '0, KEY_MAX, '0, STAMP_MIN, 0);
		issue_op(OP_INSERT, KEY_MAX, KEY_MAX, '0, KEY_MAX, STAMP_MAX, 0);
		issue_op(OP_INSERT, '0, KEY_MAX, 31'd5, 31'd6, 64'sd0, 0);
		issue_op(OP_INSERT, KEY_MAX, '0, 31'd7, 31'd8, -64'sd1, 0);
		issue_op(OP_LOOKUP, '0, '0, '0, '0, '0, 0);
		issue_op(OP_LOOKUP, KEY_MAX, KEY_MAX, '0, '0, '0, 0);
		issue_op(OP_PROBE, '0, KEY_MAX, '0, '0, '0, 0);
		issue_op(OP_PROBE, 31'd1, 31'd1, '0, '0, '0, 0);
		issue_op(OP_TOUCH, KEY_MAX, '0, '0, '0, -64'sd5, 0);
		issue_op(OP_TOUCH, KEY_MAX, '0, '0, '0, 64'sd100, 0);
		issue_op(OP_TOUCH, 31'd5, 31'd5, '0, '0, STAMP_MAX, 0);
		issue_op(OP_INSERT, '0, '0, 31'd1, 31'd2, 64'sd10, 0);
		issue_op(OP_REMOVE, '0, KEY_MAX, '0, '0, '0, 0);
		issue_op(OP_REMOVE, '0, KEY_MAX, '0, '0, '0, 0);
		issue_op(OP_SWEEP, '0, '0, '0, '0, 64'sd50, 0);
		issue_op(OP_SWEEP, '0, '0, '0, '0, STAMP_MIN, 0);
		issue_op(OP_SPARE, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, -64'sd1, 0);
		issue_op(OP_LOOKUP, '0, '0, '0, '0, '0, 0);
		issue_op(OP_CLEAR, '0, '0, '0, '0, '0, 0);
		issue_op(OP_CLEAR, '0, '0, '0, '0, '0, 0);
		issue_op(OP_SWEEP, '0, '0, '0, '0, STAMP_MAX, 0);

		// Phases do not clear the cache, so lowering the capacity leaves the occupancy
		// above it for a while.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			cap_val = (cap_plan[ph] < 0) ? CAP_W'($urandom_range(1, ENTRIES))
				: CAP_W'(cap_plan[ph]);
			write_capacity(cap_val);
			for (int k = 0; k < 5; k++) begin
				cluster_pool[k] = KEY_W'($urandom);
				proc_pool[k] = KEY_W'($urandom);
			end
			stamp_base = $signed({$urandom, $urandom}) >>> 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = pick_op(fill_plan[ph]);
				issue_op(op, pick_key(cluster_pool), pick_key(proc_pool), KEY_W'($urandom),
					KEY_W'($urandom), pick_stamp((op == OP_SWEEP) ? 300 : 1000),
					gap_plan[ph]);
			end
		end

		wait_drained();
		$display("Ran %0d operations over %0d capacity settings with 0, 20 and 60 percent gaps;",
			ops_sent, PHASES + 1);
		$display("%0d results checked, %0d hits, %0d evictions.",
			results_seen, hits_seen, evictions_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lic_pkg.sv
rtl/lic_rank_update.sv
rtl/lru_id_cache_unit.sv
rtl/lic_checker.sv
tb/sv/lic_result_checker.sv
tb/sv/tb_top.sv
